/* hdl/lsbb_pkg.sv */
// lsbb_pkg: shared types and constants for the lsb-first bit stream buffer
// field widths, operation and status codes, stream packing layout
// no dependencies
package lsbb_pkg;

  localparam int VALUE_W      = 32;
  localparam int BITCNT_W     = 6;
  localparam int STATUS_W     = 2;
  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = 40;
  localparam int USER_W       = 1;

  // a 32-bit field at any bit offset spans at most five bytes
  localparam int GATHER_BYTES = 5;
  localparam int GATHER_W     = GATHER_BYTES * 8;
  localparam int GATHER_IDX_W = 3;

  typedef logic [7:0]          byte_t;
  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam status_t STATUS_OK         = 2'd0;
  localparam status_t STATUS_WRITE_FULL = 2'd1;
  localparam status_t STATUS_READ_PAST  = 2'd2;

endpackage

/* hdl/lsbb_ram.sv */
// lsbb_ram: generic simple dual-port ram, one write and one read port
// read data is registered, valid in the cycle after the address
// no dependencies
module lsbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/lsb_first_bit_stream_buffer.sv */
// lsb_first_bit_stream_buffer: top level of the lsb-first bit stream buffer
// depends on lsbb_pkg and lsbb_ram
//
// Bit stream buffer over a byte-wide ram of BUFFER_BYTES bytes with separate
// write and read bit positions. A write transfer (tuser 0) appends the low
// bit_count bits of value, lsb first, ORing one bits into the stream; a read
// transfer (tuser 1) returns bit_count bits from the read position, first bit
// in bit 0. Counts above MAX_BITS are saturated. A write past capacity is
// dropped with status 1, a read past capacity returns zero with status 2.
// One item is handled at a time by a byte sequencer around the single ram
// port pair: an item touching B = ceil(((pos mod 8) + count) / 8) bytes goes
// through check, run (B byte reads), align and done before the next transfer
// is taken; a refused or zero-count item goes from check to done. Each byte
// a write touches is rewritten, bytes at or beyond the write fill mark read as
// zero, so no clearing pass follows reset and the block is ready at once.
module lsb_first_bit_stream_buffer
  import lsbb_pkg::*;
#(
  parameter int BUFFER_BYTES = 1024,
  parameter int MAX_BITS     = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [31:0] value, [37:32] bit_count, [39:38] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [0] op
  input  logic [USER_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [31:0] read_value, [33:32] status, [39:34] zero
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int CAP_BITS = BUFFER_BYTES * 8;
  localparam int POS_W    = $clog2(CAP_BITS + 1);
  localparam int ADDR_W   = $clog2(BUFFER_BYTES);
  localparam int CNT_W    = $clog2(MAX_BITS + 1);
  localparam int CMP_W    = (CNT_W > BITCNT_W) ? CNT_W : BITCNT_W;
  localparam int NB_W     = CNT_W - 2;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_ALIGN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]       state;
  logic [POS_W-1:0] write_bit_pos;
  logic [POS_W-1:0] read_bit_pos;

  logic             op_r;
  value_t           value_r;
  logic [CNT_W-1:0] cnt;
  logic [POS_W-1:0] pos_r;
  logic [ADDR_W-1:0] base;
  logic [NB_W-1:0]  nbytes;
  logic [NB_W-1:0]  issue_k;
  logic             rd_pend;
  logic [ADDR_W-1:0] pend_addr;
  logic [GATHER_W-1:0] wsh;
  logic [GATHER_BYTES-1:0][7:0] gather;
  logic [GATHER_IDX_W-1:0] gk;
  value_t           result;
  status_t          status_r;

  function automatic value_t low_mask(input logic [CNT_W-1:0] n);
    value_t m;
    for (int i = 0; i < VALUE_W; i++) begin
      m[i] = ((CNT_W + 1)'(i) < {1'b0, n});
    end
    return m;
  endfunction

  // input decode and count saturation
  logic [CMP_W-1:0] bc_ext;
  logic [CNT_W-1:0] cnt_in;
  logic             accept;

  assign bc_ext   = CMP_W'(s_tdata[VALUE_W +: BITCNT_W]);
  assign cnt_in   = (bc_ext > CMP_W'(MAX_BITS)) ? CNT_W'(MAX_BITS) : CNT_W'(bc_ext);
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // capacity check and byte span
  logic [POS_W:0] end_pos;
  logic [CNT_W:0] span;
  logic           refuse;

  assign end_pos = (POS_W + 1)'(pos_r) + (POS_W + 1)'(cnt);
  assign refuse  = end_pos > (POS_W + 1)'(CAP_BITS);
  assign span    = (CNT_W + 1)'(pos_r[2:0]) + (CNT_W + 1)'(cnt) + (CNT_W + 1)'(7);

  // bytes below the write fill mark have been written, the rest read as zero
  logic [POS_W:0] fill;
  byte_t          rdata;
  byte_t          byte_in;
  logic           ram_we;
  byte_t          ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;

  assign fill    = ({1'b0, write_bit_pos} + (POS_W + 1)'(7)) >> 3;
  assign byte_in = ((POS_W + 1)'(pend_addr) < fill) ? rdata : 8'h00;

  assign ram_raddr = base + ADDR_W'(issue_k);
  assign ram_we    = (state == ST_RUN) && rd_pend && (op_r == OP_WRITE);
  assign ram_wdata = byte_in | wsh[7:0];

  lsbb_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pend_addr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  logic [GATHER_W-1:0] gather_shift;
  assign gather_shift = GATHER_W'(gather) >> pos_r[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      write_bit_pos <= '0;
      read_bit_pos  <= '0;
      rd_pend       <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op_r    <= s_tuser[0];
            value_r <= s_tdata[VALUE_W-1:0] & low_mask(cnt_in);
            cnt     <= cnt_in;
            pos_r   <= (s_tuser[0] == OP_READ) ? read_bit_pos : write_bit_pos;
            state   <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          result  <= '0;
          wsh     <= GATHER_W'(value_r) << pos_r[2:0];
          base    <= ADDR_W'(pos_r >> 3);
          nbytes  <= NB_W'(span >> 3);
          issue_k <= '0;
          gk      <= '0;
          rd_pend <= 1'b0;
          if (refuse) begin
            status_r <= (op_r == OP_READ) ? STATUS_READ_PAST : STATUS_WRITE_FULL;
            state    <= ST_DONE;
          end else if (cnt == '0) begin
            status_r <= STATUS_OK;
            state    <= ST_DONE;
          end else begin
            status_r <= STATUS_OK;
            state    <= ST_RUN;
          end
        end
        ST_RUN: begin
          // issue the next byte read while the previous byte is merged
          if (issue_k != nbytes) begin
            pend_addr <= ram_raddr;
            issue_k   <= issue_k + 1'b1;
            rd_pend   <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            state   <= ST_ALIGN;
          end
          if (rd_pend) begin
            wsh <= wsh >> 8;
            if (gk < GATHER_IDX_W'(GATHER_BYTES)) begin
              gather[gk] <= byte_in;
              gk         <= gk + 1'b1;
            end
          end
        end
        ST_ALIGN: begin
          if (op_r == OP_READ) begin
            result       <= gather_shift[VALUE_W-1:0] & low_mask(cnt);
            read_bit_pos <= read_bit_pos + POS_W'(cnt);
          end else begin
            write_bit_pos <= write_bit_pos + POS_W'(cnt);
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= OUT_DATA_W'({status_r, result});
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* dv/tb.sv */
// tb: self-checking testbench for lsb_first_bit_stream_buffer
// drives a stimulus table, then random write/read mixes under three idle patterns
// depends on lsbb_pkg and the buffer rtl; results are checked against a bit-level mirror or inline expectations
module tb;
  import lsbb_pkg::*;

  localparam int STORE_BYTES    = 1024;
  localparam int MAX_COUNT      = 32;
  localparam int CAP_BITS       = STORE_BYTES * 8;
  localparam int RANDOM_ITEMS   = 433;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PAD_W          = IN_DATA_W - VALUE_W - BITCNT_W;

  typedef struct packed {
    value_t  read_value;
    status_t status;
  } result_t;

  typedef struct packed {
    logic                op;
    value_t              value;
    logic [BITCNT_W-1:0] count;
    logic                typed;
    value_t              exp_value;
    status_t             exp_status;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 22;
  // writes always return zero, so their rows carry the result inline
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{OP_READ,  32'h0000_0000, 6'd32, 1'b1, 32'h0, STATUS_OK},  // fresh store reads zero
    '{OP_WRITE, 32'hffff_ffff, 6'd0,  1'b1, 32'h0, STATUS_OK},
    '{OP_READ,  32'hffff_ffff, 6'd0,  1'b1, 32'h0, STATUS_OK},
    '{OP_WRITE, 32'hffff_ffff, 6'd32, 1'b1, 32'h0, STATUS_OK},
    '{OP_WRITE, 32'h0000_00a5, 6'd8,  1'b1, 32'h0, STATUS_OK},
    '{OP_WRITE, 32'h0000_0000, 6'd63, 1'b1, 32'h0, STATUS_OK},  // saturates to 32
    '{OP_WRITE, 32'hdead_beef, 6'd33, 1'b1, 32'h0, STATUS_OK},
    '{OP_WRITE, 32'h0000_0001, 6'd1,  1'b1, 32'h0, STATUS_OK},
    '{OP_WRITE, 32'h0000_0006, 6'd3,  1'b1, 32'h0, STATUS_OK},
    '{OP_WRITE, 32'h0001_2345, 6'd17, 1'b1, 32'h0, STATUS_OK},
    '{OP_WRITE, 32'h5555_5555, 6'd31, 1'b1, 32'h0, STATUS_OK},
    '{OP_READ,  32'h0000_0000, 6'd63, 1'b0, 32'h0, STATUS_OK},
    '{OP_READ,  32'h0000_0000, 6'd7,  1'b0, 32'h0, STATUS_OK},
    '{OP_READ,  32'h0000_0000, 6'd33, 1'b0, 32'h0, STATUS_OK},
    '{OP_READ,  32'h0000_0000, 6'd5,  1'b0, 32'h0, STATUS_OK},
    '{OP_READ,  32'h0000_0000, 6'd1,  1'b0, 32'h0, STATUS_OK},
    '{OP_READ,  32'h0000_0000, 6'd32, 1'b0, 32'h0, STATUS_OK},
    '{OP_READ,  32'h0000_0000, 6'd15, 1'b0, 32'h0, STATUS_OK},
    '{OP_READ,  32'h0000_0000, 6'd8,  1'b0, 32'h0, STATUS_OK},  // ahead of the writer
    '{OP_WRITE, 32'haaaa_aaaa, 6'd32, 1'b1, 32'h0, STATUS_OK},
    '{OP_READ,  32'h0000_0000, 6'd24, 1'b0, 32'h0, STATUS_OK},
    '{OP_READ,  32'h0000_0000, 6'd32, 1'b0, 32'h0, STATUS_OK}
  };

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [USER_W-1:0]     s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  // bit-level mirror of the buffer
  logic [7:0]  mirror_bytes [STORE_BYTES];
  int unsigned mirror_wr_pos;
  int unsigned mirror_rd_pos;

  result_t pending_results [$];
  result_t oldest;
  int      fail_count;
  int      stall_cycles;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      holds_requested;
  int      holds_served;
  int      hold_left;

  lsb_first_bit_stream_buffer #(
    .BUFFER_BYTES(STORE_BYTES),
    .MAX_BITS    (MAX_COUNT)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void bitstream_step(input logic op, input value_t value,
                                         input logic [BITCNT_W-1:0] count,
                                         output result_t res);
    int unsigned n;
    int unsigned p;
    n = (count > MAX_COUNT) ? MAX_COUNT : count;
    res.read_value = '0;
    res.status     = STATUS_OK;
    if (op == OP_WRITE) begin
      if (mirror_wr_pos + n > CAP_BITS) begin
        res.status = STATUS_WRITE_FULL;
      end else begin
        for (int i = 0; i < n; i++) begin
          p = mirror_wr_pos + i;
          if (value[i]) mirror_bytes[p / 8][p % 8] = 1'b1;
        end
        mirror_wr_pos += n;
      end
    end else begin
      if (mirror_rd_pos + n > CAP_BITS) begin
        res.status = STATUS_READ_PAST;
      end else begin
        for (int i = 0; i < n; i++) begin
          p = mirror_rd_pos + i;
          res.read_value[i] = mirror_bytes[p / 8][p % 8];
        end
        mirror_rd_pos += n;
      end
    end
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic push_item(input logic op, input value_t value,
                           input logic [BITCNT_W-1:0] count, input logic typed,
                           input value_t exp_value, input status_t exp_status);
    result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{PAD_W{1'b0}}, count, value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bitstream_step(op, value, count, res);
    if (typed) begin
      res.read_value = exp_value;
      res.status     = exp_status;
    end
    pending_results.push_back(res);
    @(negedge clk);
  endtask

  task automatic push_random_item();
    logic                op;
    value_t              value;
    logic [BITCNT_W-1:0] count;
    int unsigned         pos;
    int                  r;
    r = $urandom_range(99);
    // keep most reads behind the writer so they return written data
    if (mirror_rd_pos >= mirror_wr_pos && mirror_wr_pos < CAP_BITS)
      op = (r < 15) ? OP_READ : OP_WRITE;
    else
      op = (r < 45) ? OP_READ : OP_WRITE;
    r = $urandom_range(99);
    if (r < 10)      count = BITCNT_W'($urandom_range(63, 33));
    else if (r < 25) count = BITCNT_W'(MAX_COUNT);
    else if (r < 40) count = BITCNT_W'($urandom_range(7, 0));
    else             count = BITCNT_W'($urandom_range(16, 1));
    // near the end, sometimes land exactly on capacity
    pos = (op == OP_WRITE) ? mirror_wr_pos : mirror_rd_pos;
    if (pos < CAP_BITS && CAP_BITS - pos <= MAX_COUNT && $urandom_range(3) == 0)
      count = BITCNT_W'(CAP_BITS - pos);
    r = $urandom_range(99);
    if (r < 10)      value = '1;
    else if (r < 20) value = '0;
    else             value = $urandom;
    push_item(op, value, count, 1'b0, '0, STATUS_OK);
  endtask

  // receiver: random ready, plus long hold-offs on request
  initial begin
    m_tready     = 1'b0;
    holds_served = 0;
    hold_left    = 0;
  end

  always @(negedge clk) begin
    if (hold_left == 0 && holds_served != holds_requested) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected, got %h", $time, m_tdata);
        fail_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (m_tdata[VALUE_W-1:0] !== oldest.read_value) begin
          $display("%0t: read_value expected %h got %h", $time, oldest.read_value,
                   m_tdata[VALUE_W-1:0]);
          fail_count++;
        end
        if (m_tdata[VALUE_W +: STATUS_W] !== oldest.status) begin
          $display("%0t: status expected %0d got %0d", $time, oldest.status,
                   m_tdata[VALUE_W +: STATUS_W]);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst             = 1'b1;
    s_tvalid        = 1'b0;
    s_tuser         = '0;
    s_tdata         = '0;
    fail_count      = 0;
    stall_cycles    = 0;
    holds_requested = 0;
    send_idle_pct   = 9;
    recv_idle_pct   = 73;
    mirror_wr_pos   = 0;
    mirror_rd_pos   = 0;
    for (int i = 0; i < STORE_BYTES; i++) mirror_bytes[i] = 8'h00;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++)
      push_item(DIRECTED[i].op, DIRECTED[i].value, DIRECTED[i].count, DIRECTED[i].typed,
                DIRECTED[i].exp_value, DIRECTED[i].exp_status);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          holds_requested++;  // fill the block while the receiver stalls
        end
      endcase
      for (int i = 0; i < RANDOM_ITEMS; i++) push_random_item();
    end

    // run both positions to capacity, then step past it
    while (mirror_wr_pos < CAP_BITS)
      push_item(OP_WRITE, $urandom,
                BITCNT_W'((CAP_BITS - mirror_wr_pos > MAX_COUNT) ?
                          MAX_COUNT : CAP_BITS - mirror_wr_pos),
                1'b0, '0, STATUS_OK);
    push_item(OP_WRITE, 32'hffff_ffff, 6'd1, 1'b1, 32'h0, STATUS_WRITE_FULL);
    push_item(OP_WRITE, 32'hffff_ffff, 6'd0, 1'b1, 32'h0, STATUS_OK);
    while (mirror_rd_pos < CAP_BITS)
      push_item(OP_READ, '0,
                BITCNT_W'((CAP_BITS - mirror_rd_pos > MAX_COUNT) ?
                          MAX_COUNT : CAP_BITS - mirror_rd_pos),
                1'b0, '0, STATUS_OK);
    push_item(OP_READ, '0, 6'd1,  1'b1, 32'h0, STATUS_READ_PAST);
    push_item(OP_READ, '0, 6'd32, 1'b1, 32'h0, STATUS_READ_PAST);
    push_item(OP_READ, '0, 6'd0,  1'b1, 32'h0, STATUS_OK);
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
